### hdl/srps_pkg.sv
// Package with shared types and constants of the stepper ramp profile sequencer.
`default_nettype none

package srps_pkg;

	// Field and register widths.
	localparam int unsigned PERIOD_W  = 16;
	localparam int unsigned STEPS_W   = 16;
	localparam int unsigned PROD_W    = 2 * PERIOD_W;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned DIV_CNT_W = $clog2(PROD_W);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_START_HALF_PERIOD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HALF_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS         = 2'd2;

	// Configuration reset values.
	localparam logic [PERIOD_W-1:0] RST_START_HALF_PERIOD  = 16'd3000;
	localparam logic [PERIOD_W-1:0] RST_TARGET_HALF_PERIOD = 16'd400;
	localparam logic [STEPS_W-1:0]  RST_RAMP_STEPS         = 16'd600;

	// Run phase codes as reported on the output.
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_ACCEL  = 3'd1,
		PH_CRUISE = 3'd2,
		PH_HOLD   = 3'd3,
		PH_DECEL  = 3'd4
	} phase_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                load_mul;
		logic                div_step;
		logic [STEPS_W-1:0]  ramp_index;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic                last;
		logic [PERIOD_W-1:0] fast_period;
		logic [PERIOD_W-1:0] accel_period;
		logic [PERIOD_W-1:0] decel_period;
	} dp_sts_t;

endpackage

`default_nettype wire

### hdl/srps_if.sv
// Handshake channel interfaces for slot items, result items and configuration writes.
`default_nettype none

interface srps_in_if;
	logic valid;
	logic ready;
	logic start_cmd;
	logic stop_pressed;
	modport source (output valid, output start_cmd, output stop_pressed, input ready);
	modport sink (input valid, input start_cmd, input stop_pressed, output ready);
endinterface

interface srps_out_if;
	logic                          valid;
	logic                          ready;
	logic                          pulse_valid;
	logic [srps_pkg::PERIOD_W-1:0] half_period_us;
	logic [2:0]                    run_phase;
	logic                          run_done;
	modport source (output valid, output pulse_valid, output half_period_us,
		output run_phase, output run_done, input ready);
	modport sink (input valid, input pulse_valid, input half_period_us,
		input run_phase, input run_done, output ready);
endinterface

interface srps_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [srps_pkg::CFG_IDX_W-1:0] index;
	logic [srps_pkg::PERIOD_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/srps_datapath.sv
// Datapath: configuration registers, ramp product and a bit-serial restoring divider.
`default_nettype none

module srps_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [srps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [srps_pkg::PERIOD_W-1:0]  cfg_data,
	input  wire srps_pkg::dp_cmd_t             cmd,
	output srps_pkg::dp_sts_t                  sts
);

	logic [srps_pkg::PERIOD_W-1:0] start_hp_q;
	logic [srps_pkg::PERIOD_W-1:0] target_hp_q;
	logic [srps_pkg::STEPS_W-1:0]  ramp_steps_q;

	logic [srps_pkg::PERIOD_W-1:0] slow;
	logic [srps_pkg::PERIOD_W-1:0] fast;
	logic [srps_pkg::PERIOD_W-1:0] delta;
	logic [srps_pkg::STEPS_W-1:0]  n_len;
	logic [srps_pkg::STEPS_W:0]    idx_p1;
	logic                          last;
	logic [srps_pkg::STEPS_W-1:0]  k_mul;
	logic [srps_pkg::PROD_W-1:0]   product;

	logic [srps_pkg::PROD_W-1:0]   quo_q;
	logic [srps_pkg::STEPS_W-1:0]  rem_q;
	logic [srps_pkg::STEPS_W:0]    trial;
	logic                          trial_ge;

	// Configuration registers; every write beat is taken at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_hp_q   <= srps_pkg::RST_START_HALF_PERIOD;
			target_hp_q  <= srps_pkg::RST_TARGET_HALF_PERIOD;
			ramp_steps_q <= srps_pkg::RST_RAMP_STEPS;
		end else if (cfg_we) begin
			case (cfg_index)
				srps_pkg::CFG_START_HALF_PERIOD:  start_hp_q   <= cfg_data;
				srps_pkg::CFG_TARGET_HALF_PERIOD: target_hp_q  <= cfg_data;
				srps_pkg::CFG_RAMP_STEPS:         ramp_steps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Order the two periods and clamp the step count and the ramp position.
	always_comb begin
		if (start_hp_q >= target_hp_q) begin
			slow = start_hp_q;
			fast = target_hp_q;
		end else begin
			slow = target_hp_q;
			fast = start_hp_q;
		end
		delta  = slow - fast;
		n_len  = (ramp_steps_q == '0) ? srps_pkg::STEPS_W'(1) : ramp_steps_q;
		idx_p1 = {1'b0, cmd.ramp_index} + (srps_pkg::STEPS_W+1)'(1);
		last   = (idx_p1 >= {1'b0, n_len});
		k_mul  = last ? n_len : idx_p1[srps_pkg::STEPS_W-1:0];
		product = srps_pkg::PROD_W'(delta) * srps_pkg::PROD_W'(k_mul);
	end

	// Restoring division, one quotient bit per cycle shifted into the dividend.
	assign trial    = {rem_q, quo_q[srps_pkg::PROD_W-1]};
	assign trial_ge = (trial >= {1'b0, n_len});

	always_ff @(posedge clk) begin
		if (cmd.load_mul) begin
			quo_q <= product;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (trial_ge) begin
				rem_q <= srps_pkg::STEPS_W'(trial - {1'b0, n_len});
			end else begin
				rem_q <= trial[srps_pkg::STEPS_W-1:0];
			end
			quo_q <= {quo_q[srps_pkg::PROD_W-2:0], trial_ge};
		end
	end

	// The quotient never exceeds delta, so its low half is the whole value.
	assign sts.last         = last;
	assign sts.fast_period  = fast;
	assign sts.accel_period = slow - quo_q[srps_pkg::PERIOD_W-1:0];
	assign sts.decel_period = fast + quo_q[srps_pkg::PERIOD_W-1:0];

endmodule

`default_nettype wire

### hdl/srps_ctrl.sv
// Controller: slot handshake, run phase state, ramp index, sequencing and result register.
`default_nettype none

module srps_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           start_cmd,
	input  wire logic                           stop_pressed,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                pulse_valid,
	output logic [srps_pkg::PERIOD_W-1:0]       half_period_us,
	output logic [2:0]                          run_phase,
	output logic                                run_done,
	output srps_pkg::dp_cmd_t                   cmd,
	input  wire srps_pkg::dp_sts_t              sts
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_LOAD = 4'b1000
	} state_t;

	state_t                          state_q;
	srps_pkg::phase_t                phase_q;
	logic [srps_pkg::STEPS_W-1:0]    ramp_index_q;
	logic [srps_pkg::DIV_CNT_W-1:0]  div_cnt_q;
	logic                            stop_q;
	logic                            ramp_q;
	logic                            decel_q;

	logic                            out_valid_q;
	logic                            out_pulse_q;
	logic [srps_pkg::PERIOD_W-1:0]   out_period_q;
	srps_pkg::phase_t                out_phase_q;
	logic                            out_done_q;

	logic                            accept;
	logic                            load;
	logic                            acc_ramp;
	logic                            acc_decel;
	logic                            acc_zero_idx;
	logic                            ld_pulse;
	logic [srps_pkg::PERIOD_W-1:0]   ld_period;
	srps_pkg::phase_t                ld_phase;
	logic                            ld_done;
	srps_pkg::phase_t                nxt_phase;
	logic [srps_pkg::STEPS_W-1:0]    nxt_index;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load     = (state_q == ST_LOAD) && (!out_valid_q || out_ready);

	// Classify an incoming slot: ramp slots need the product and the divide.
	always_comb begin
		acc_ramp     = 1'b0;
		acc_decel    = 1'b0;
		acc_zero_idx = 1'b0;
		case (phase_q)
			srps_pkg::PH_ACCEL: acc_ramp = 1'b1;
			srps_pkg::PH_CRUISE: acc_zero_idx = 1'b1;
			srps_pkg::PH_HOLD: begin
				acc_zero_idx = 1'b1;
				if (!stop_pressed) begin
					acc_ramp  = 1'b1;
					acc_decel = 1'b1;
				end
			end
			srps_pkg::PH_DECEL: begin
				acc_ramp  = 1'b1;
				acc_decel = 1'b1;
			end
			default: begin
				acc_zero_idx = 1'b1;
				acc_ramp     = start_cmd;
			end
		endcase
	end

	// Result and next phase of the slot being finished.
	always_comb begin
		ld_pulse  = 1'b1;
		ld_period = sts.fast_period;
		ld_phase  = phase_q;
		ld_done   = 1'b0;
		nxt_phase = phase_q;
		nxt_index = '0;
		if (ramp_q && !decel_q) begin
			ld_period = sts.accel_period;
			ld_phase  = srps_pkg::PH_ACCEL;
			if (stop_q) begin
				nxt_phase = srps_pkg::PH_HOLD;
			end else if (sts.last) begin
				nxt_phase = srps_pkg::PH_CRUISE;
			end else begin
				nxt_phase = srps_pkg::PH_ACCEL;
				nxt_index = ramp_index_q + srps_pkg::STEPS_W'(1);
			end
		end else if (ramp_q) begin
			ld_period = sts.decel_period;
			ld_phase  = srps_pkg::PH_DECEL;
			ld_done   = sts.last;
			if (sts.last) begin
				nxt_phase = srps_pkg::PH_IDLE;
			end else begin
				nxt_phase = srps_pkg::PH_DECEL;
				nxt_index = ramp_index_q + srps_pkg::STEPS_W'(1);
			end
		end else begin
			case (phase_q)
				srps_pkg::PH_CRUISE: begin
					ld_phase  = stop_q ? srps_pkg::PH_HOLD : srps_pkg::PH_CRUISE;
					nxt_phase = ld_phase;
				end
				srps_pkg::PH_HOLD: begin
					ld_phase  = srps_pkg::PH_HOLD;
					nxt_phase = srps_pkg::PH_HOLD;
				end
				default: begin
					ld_pulse  = 1'b0;
					ld_period = '0;
					ld_phase  = srps_pkg::PH_IDLE;
					nxt_phase = srps_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// Sequencer and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= srps_pkg::PH_IDLE;
			ramp_index_q <= '0;
			div_cnt_q    <= '0;
			stop_q       <= 1'b0;
			ramp_q       <= 1'b0;
			decel_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						stop_q  <= stop_pressed;
						ramp_q  <= acc_ramp;
						decel_q <= acc_decel;
						if (acc_zero_idx) begin
							ramp_index_q <= '0;
						end
						state_q <= acc_ramp ? ST_MUL : ST_LOAD;
					end
				end
				ST_MUL: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + srps_pkg::DIV_CNT_W'(1);
					if (div_cnt_q == '1) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (load) begin
						phase_q      <= nxt_phase;
						ramp_index_q <= nxt_index;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register: holds one finished beat while the next slot is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_pulse_q  <= ld_pulse;
			out_period_q <= ld_period;
			out_phase_q  <= ld_phase;
			out_done_q   <= ld_done;
		end
	end

	assign out_valid      = out_valid_q;
	assign pulse_valid    = out_pulse_q;
	assign half_period_us = out_period_q;
	assign run_phase      = out_phase_q;
	assign run_done       = out_done_q;

	assign cmd.load_mul   = (state_q == ST_MUL);
	assign cmd.div_step   = (state_q == ST_DIV);
	assign cmd.ramp_index = ramp_index_q;

	// A done beat is always a decel pulse.
	a_done_is_decel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> (out_pulse_q && out_phase_q == srps_pkg::PH_DECEL))
		else $error("run_done outside a decel pulse");

	// A beat without a pulse is an idle beat with a zero period.
	a_no_pulse_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_pulse_q) |->
		(out_period_q == '0 && out_phase_q == srps_pkg::PH_IDLE))
		else $error("non-pulse beat carries a period or a run phase");

	// The divide hands over to the load state after its last count.
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q == '1) |=> (state_q == ST_LOAD))
		else $error("divider did not hand over to the load state");

	// Between slots, a nonzero ramp index only exists inside a ramp.
	a_index_in_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && ramp_index_q != '0) |->
		(phase_q == srps_pkg::PH_ACCEL || phase_q == srps_pkg::PH_DECEL))
		else $error("ramp index left set outside a ramp");

endmodule

`default_nettype wire

### hdl/stepper_ramp_profile_sequencer.sv
// Top level of the stepper ramp profile sequencer: controller, datapath and channel wiring.
// Sequence: a ramp slot (accel or decel) passes from its input beat to its result beat through
//   the product state, the bit-serial divider and the load state into the result register.
// Other slots (idle, cruise, stop hold) go from the accept straight to the load state.
// A new slot is taken only after the previous one has been loaded into the result register.
// Reset (arst_n low) returns the run to idle with ramp index zero and loads the default
//   configuration of 3000 us, 400 us and 600 steps; no result beat is pending after reset.
`default_nettype none

module stepper_ramp_profile_sequencer (
	input  wire logic clk,
	input  wire logic arst_n,
	srps_cfg_if.sink  cfg,
	srps_in_if.sink   step_in,
	srps_out_if.source step_out
);

	srps_pkg::dp_cmd_t dp_cmd;
	srps_pkg::dp_sts_t dp_sts;

	// Configuration beats are always taken.
	assign cfg.ready = 1'b1;

	srps_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (step_in.valid),
		.in_ready       (step_in.ready),
		.start_cmd      (step_in.start_cmd),
		.stop_pressed   (step_in.stop_pressed),
		.out_valid      (step_out.valid),
		.out_ready      (step_out.ready),
		.pulse_valid    (step_out.pulse_valid),
		.half_period_us (step_out.half_period_us),
		.run_phase      (step_out.run_phase),
		.run_done       (step_out.run_done),
		.cmd            (dp_cmd),
		.sts            (dp_sts)
	);

	srps_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (dp_cmd),
		.sts       (dp_sts)
	);

endmodule

`default_nettype wire

### dv/srps_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the step pulse of every slot and compares it with the result beats.
module srps_checker
	import srps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	srps_cfg_if         cfg_ch,
	srps_in_if          in_ch,
	srps_out_if         out_ch,
	output int unsigned mismatch_count,
	output int unsigned pulses_outstanding
);

	localparam int unsigned MAX_PRINTED = 200;

	typedef struct packed {
		logic                pulse;
		logic [PERIOD_W-1:0] half_period;
		phase_t              phase;
		logic                done;
	} step_pulse_t;

	// Shadow copy of the configuration and of the run state.
	logic [PERIOD_W-1:0] start_hp;
	logic [PERIOD_W-1:0] target_hp;
	logic [STEPS_W-1:0]  ramp_len_cfg;
	phase_t              run_phase_q;
	logic [STEPS_W-1:0]  ramp_idx_q;

	step_pulse_t expected_pulses[$];
	step_pulse_t want;
	int unsigned errors = 0;
	int unsigned results_seen = 0;

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINTED) begin
			$display("%0t: result %0d: %s", $time, results_seen, what);
		end
	endtask

	function automatic logic [PERIOD_W-1:0] slow_hp();
		return (start_hp >= target_hp) ? start_hp : target_hp;
	endfunction

	function automatic logic [PERIOD_W-1:0] fast_hp();
		return (start_hp >= target_hp) ? target_hp : start_hp;
	endfunction

	// Ramp offset delta*k/n with k = min(index+1, n); a saturated step is the ramp's last.
	function automatic logic [PERIOD_W-1:0] ramp_offset(output logic last);
		longint unsigned n;
		longint unsigned k;
		longint unsigned delta;
		n = (ramp_len_cfg == '0) ? 64'd1 : 64'(ramp_len_cfg);
		k = 64'(ramp_idx_q) + 64'd1;
		delta = 64'(slow_hp()) - 64'(fast_hp());
		last = (k >= n);
		if (last) begin
			k = n;
		end
		return PERIOD_W'((delta * k) / n);
	endfunction

	// One accel step; stop sends the run to stop hold even before the ramp ends.
	task automatic accel_slot(input logic stop, output step_pulse_t p);
		logic                last;
		logic [PERIOD_W-1:0] ofs;
		ofs = ramp_offset(last);
		p.pulse = 1'b1;
		p.half_period = slow_hp() - ofs;
		p.phase = PH_ACCEL;
		p.done = 1'b0;
		if (stop) begin
			run_phase_q = PH_HOLD;
			ramp_idx_q = '0;
		end else if (last) begin
			run_phase_q = PH_CRUISE;
			ramp_idx_q = '0;
		end else begin
			run_phase_q = PH_ACCEL;
			ramp_idx_q = ramp_idx_q + 1'b1;
		end
	endtask

	// One decel step; the last one flags the end of the run and returns to idle.
	task automatic decel_slot(output step_pulse_t p);
		logic                last;
		logic [PERIOD_W-1:0] ofs;
		ofs = ramp_offset(last);
		p.pulse = 1'b1;
		p.half_period = fast_hp() + ofs;
		p.phase = PH_DECEL;
		p.done = last;
		if (last) begin
			run_phase_q = PH_IDLE;
			ramp_idx_q = '0;
		end else begin
			run_phase_q = PH_DECEL;
			ramp_idx_q = ramp_idx_q + 1'b1;
		end
	endtask

	// Works out the result of one slot and queues it.
	task automatic predict_step_pulse(input logic start, input logic stop);
		step_pulse_t p;
		// All zero is the idle result: no pulse, idle phase.
		p = '0;
		case (run_phase_q)
			PH_ACCEL: accel_slot(stop, p);
			PH_CRUISE: begin
				p.pulse = 1'b1;
				p.half_period = fast_hp();
				p.phase = PH_CRUISE;
				if (stop) begin
					p.phase = PH_HOLD;
					run_phase_q = PH_HOLD;
				end
				ramp_idx_q = '0;
			end
			PH_HOLD: begin
				ramp_idx_q = '0;
				if (stop) begin
					p.pulse = 1'b1;
					p.half_period = fast_hp();
					p.phase = PH_HOLD;
				end else begin
					decel_slot(p);
				end
			end
			PH_DECEL: decel_slot(p);
			default: begin
				run_phase_q = PH_IDLE;
				ramp_idx_q = '0;
				if (start) begin
					accel_slot(stop, p);
				end
			end
		endcase
		expected_pulses.push_back(p);
	endtask

	// Beats are sampled at the clock edge, before any input driven at that edge changes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_hp = RST_START_HALF_PERIOD;
			target_hp = RST_TARGET_HALF_PERIOD;
			ramp_len_cfg = RST_RAMP_STEPS;
			run_phase_q = PH_IDLE;
			ramp_idx_q = '0;
			expected_pulses.delete();
			mismatch_count <= errors;
			pulses_outstanding <= 0;
		end else begin
			// Register writes take effect from the next slot.
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					CFG_START_HALF_PERIOD:  start_hp = cfg_ch.data;
					CFG_TARGET_HALF_PERIOD: target_hp = cfg_ch.data;
					CFG_RAMP_STEPS:         ramp_len_cfg = cfg_ch.data;
					default: ;
				endcase
			end

			// Compare a result beat with the oldest expectation, field by field.
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (expected_pulses.size() == 0) begin
					report_mismatch("result beat with no slot outstanding");
				end else begin
					want = expected_pulses.pop_front();
					if (out_ch.pulse_valid !== want.pulse) begin
						report_mismatch($sformatf("pulse_valid %b, expected %b",
							out_ch.pulse_valid, want.pulse));
					end
					if (out_ch.half_period_us !== want.half_period) begin
						report_mismatch($sformatf("half_period_us %0d, expected %0d",
							out_ch.half_period_us, want.half_period));
					end
					if (out_ch.run_phase !== want.phase) begin
						report_mismatch($sformatf("run_phase %0d, expected %0d",
							out_ch.run_phase, want.phase));
					end
					if (out_ch.run_done !== want.done) begin
						report_mismatch($sformatf("run_done %b, expected %b",
							out_ch.run_done, want.done));
					end
				end
			end

			// Predict after the compare so a beat in the same cycle cannot match itself.
			if (in_ch.valid && in_ch.ready) begin
				predict_step_pulse(in_ch.start_cmd, in_ch.stop_pressed);
			end

			mismatch_count <= errors;
			pulses_outstanding <= expected_pulses.size();
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, slot and register stimulus, result back-pressure and verdict.
module testbench;
	import srps_pkg::*;

	localparam int unsigned RANDOM_SLOTS = 950;
	localparam int unsigned LONG_STALL   = 300;
	localparam int unsigned SETTLE_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned mismatch_count;
	int unsigned pulses_outstanding;
	int unsigned slots_sent = 0;
	int unsigned send_idle_pct = 16;
	int unsigned recv_idle_pct;
	int unsigned stall_requests = 0;

	srps_cfg_if cfg_ch();
	srps_in_if  step_in_ch();
	srps_out_if step_out_ch();

	stepper_ramp_profile_sequencer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_ch),
		.step_in  (step_in_ch),
		.step_out (step_out_ch)
	);

	srps_checker i_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_ch             (cfg_ch),
		.in_ch              (step_in_ch),
		.out_ch             (step_out_ch),
		.mismatch_count     (mismatch_count),
		.pulses_outstanding (pulses_outstanding)
	);

	always #4 clk = ~clk;

	// Offers one slot after an optional random gap; valid stays high after the beat.
	task automatic send_slot(input logic start, input logic stop);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			step_in_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
		end
		step_in_ch.valid <= 1'b1;
		step_in_ch.start_cmd <= start;
		step_in_ch.stop_pressed <= stop;
		do @(posedge clk); while (!step_in_ch.ready);
		slots_sent++;
	endtask

	// Stops offering slots and waits until every expected result has come out.
	task automatic drain_pulses();
		step_in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pulses_outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Period values lean toward realistic speeds but hit both extremes.
	function automatic logic [PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 9))
			0:       return 16'd1;
			1:       return 16'hFFFF;
			2:       return PERIOD_W'($urandom_range(1, 65535));
			default: return PERIOD_W'($urandom_range(1, 4000));
		endcase
	endfunction

	// Result side: random stalls, plus a long hold-off whenever one is requested.
	initial begin : receiver
		int unsigned seen;
		int unsigned hold_left;
		seen = 0;
		hold_left = 0;
		step_out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_requests != seen) begin
				seen = stall_requests;
				hold_left = LONG_STALL;
			end
			if (hold_left > 0) begin
				hold_left--;
				step_out_ch.ready <= 1'b0;
			end else begin
				step_out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Hard limit on the run time.
	initial begin
		#5_000_000;
		$display("FAIL stepper_ramp_profile_sequencer");
		$finish;
	end

	initial begin : stimulus
		int unsigned directed_slots;
		int unsigned progress;
		int unsigned stalls_done;
		logic [STEPS_W-1:0] ramp;

		stalls_done = 0;
		arst_n <= 1'b0;
		recv_idle_pct <= 79;
		step_in_ch.valid <= 1'b0;
		step_in_ch.start_cmd <= 1'b0;
		step_in_ch.stop_pressed <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_START_HALF_PERIOD;
		cfg_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle ignores stop; a start with reset values, then stop cuts the accel ramp short.
		send_slot(1'b0, 1'b1);
		send_slot(1'b0, 1'b0);
		send_slot(1'b1, 1'b0);
		send_slot(1'b0, 1'b1);
		send_slot(1'b1, 1'b1);
		send_slot(1'b0, 1'b0);

		// A zero ramp length means one step: the decel index saturates and the run ends.
		drain_pulses();
		write_reg(CFG_RAMP_STEPS, 16'd0);
		send_slot(1'b0, 1'b1);

		// Periods given the wrong way round; full trapezoid with cruise, hold and decel.
		drain_pulses();
		write_reg(CFG_START_HALF_PERIOD, 16'd200);
		write_reg(CFG_TARGET_HALF_PERIOD, 16'd1000);
		write_reg(CFG_RAMP_STEPS, 16'd3);
		send_slot(1'b1, 1'b0);
		send_slot(1'b0, 1'b0);
		send_slot(1'b0, 1'b0);
		send_slot(1'b1, 1'b0);
		send_slot(1'b0, 1'b1);
		send_slot(1'b0, 1'b1);
		send_slot(1'b0, 1'b0);
		send_slot(1'b1, 1'b1);
		send_slot(1'b0, 1'b0);

		// Widest span and longest ramp, then a shorter ramp mid-run saturates the index.
		drain_pulses();
		write_reg(CFG_START_HALF_PERIOD, 16'hFFFF);
		write_reg(CFG_TARGET_HALF_PERIOD, 16'd1);
		write_reg(CFG_RAMP_STEPS, 16'hFFFF);
		send_slot(1'b1, 1'b0);
		send_slot(1'b0, 1'b0);
		drain_pulses();
		write_reg(CFG_RAMP_STEPS, 16'd2);
		send_slot(1'b0, 1'b0);
		send_slot(1'b0, 1'b0);

		// Equal periods give a flat profile; a start with stop held goes straight to hold.
		drain_pulses();
		write_reg(CFG_START_HALF_PERIOD, 16'd1);
		send_slot(1'b0, 1'b1);
		send_slot(1'b0, 1'b0);
		send_slot(1'b0, 1'b0);
		send_slot(1'b1, 1'b1);
		send_slot(1'b0, 1'b0);
		send_slot(1'b0, 1'b0);
		directed_slots = slots_sent;

		// Random runs: mostly well-formed start/run/stop/decel sequences, some noise.
		while (slots_sent < directed_slots + RANDOM_SLOTS) begin
			progress = slots_sent - directed_slots;
			if (progress < RANDOM_SLOTS / 3) begin
				send_idle_pct = 16;
				recv_idle_pct <= 79;
			end else if (progress < 2 * RANDOM_SLOTS / 3) begin
				send_idle_pct = 79;
				recv_idle_pct <= 16;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end

			if ($urandom_range(0, 2) == 0) begin
				drain_pulses();
				if ($urandom_range(0, 1) == 1) begin
					write_reg(CFG_START_HALF_PERIOD, pick_period());
				end
				if ($urandom_range(0, 1) == 1) begin
					write_reg(CFG_TARGET_HALF_PERIOD, pick_period());
				end
				if ($urandom_range(0, 1) == 1) begin
					case ($urandom_range(0, 9))
						0:       ramp = '0;
						1:       ramp = 16'hFFFF;
						2:       ramp = STEPS_W'($urandom_range(0, 65535));
						default: ramp = STEPS_W'($urandom_range(1, 12));
					endcase
					write_reg(CFG_RAMP_STEPS, ramp);
				end
			end

			// Long result stall while slots keep coming, so the block backs up.
			if ((progress >= 250 && stalls_done == 0) || (progress >= 750 && stalls_done == 1)) begin
				stall_requests <= stall_requests + 1;
				stalls_done++;
			end

			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8)) begin
					send_slot(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end else begin
				repeat ($urandom_range(0, 2)) send_slot(1'b0, 1'($urandom_range(0, 1)));
				send_slot(1'b1, $urandom_range(0, 7) == 0);
				repeat ($urandom_range(0, 16)) send_slot(1'b0, $urandom_range(0, 19) == 0);
				repeat ($urandom_range(1, 4)) send_slot(1'($urandom_range(0, 1)), 1'b1);
				repeat ($urandom_range(2, 16)) begin
					send_slot($urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
				end
			end
		end

		// Let everything come out, then give the block time to show any stray beat.
		drain_pulses();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS stepper_ramp_profile_sequencer");
		end else begin
			$display("FAIL stepper_ramp_profile_sequencer");
		end
		$finish;
	end

endmodule
